// ===== design/assert_macros.svh =====
// Shared assertion macros for the bit-logic executor
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/plcbl_pkg.sv =====
`default_nettype none

package plcbl_pkg;

  // Item kinds
  localparam logic [1:0] KIND_EXEC   = 2'd0;
  localparam logic [1:0] KIND_HWRITE = 2'd1;
  localparam logic [1:0] KIND_HREAD  = 2'd2;

  // Instruction word layout
  localparam int WORD_BITS = 16;
  localparam int OP_LSB    = 12;

  // Opcodes
  localparam logic [3:0] OPC_NOP    = 4'h0;
  localparam logic [3:0] OPC_AND    = 4'h1;
  localparam logic [3:0] OPC_ANDN   = 4'h2;
  localparam logic [3:0] OPC_OR     = 4'h3;
  localparam logic [3:0] OPC_ORN    = 4'h4;
  localparam logic [3:0] OPC_XOR    = 4'h5;
  localparam logic [3:0] OPC_XORN   = 4'h6;
  localparam logic [3:0] OPC_SET    = 4'h7;
  localparam logic [3:0] OPC_SETN   = 4'h8;
  localparam logic [3:0] OPC_RST    = 4'h9;
  localparam logic [3:0] OPC_RSTN   = 4'hA;
  localparam logic [3:0] OPC_ASSIGN = 4'hB;
  localparam logic [3:0] OPC_RSV_C  = 4'hC;
  localparam logic [3:0] OPC_RSV_D  = 4'hD;
  localparam logic [3:0] OPC_RSV_E  = 4'hE;
  localparam logic [3:0] OPC_NOP_F  = 4'hF;

  typedef logic [31:0] count_t;

endpackage

`default_nettype wire

// ===== design/plc_bit_logic_executor_top.sv =====
// An accepted input beat passes the execute register, then the result
// register. Throughput: one item per cycle unless out_ready stalls; the bit
// memory is read once at accept and written at most once when the item
// leaves the execute register. Reset: synchronous, active high. After reset
// it clears all 2^ADDR_BITS (4096 by default) memory bits one a cycle,
// with in_ready low; accumulator, chain flag and counters clear at once.
`default_nettype none

`include "assert_macros.svh"

module plc_bit_logic_executor_top
  import plcbl_pkg::*;
#(
  parameter int ADDR_BITS = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           kind,
  input  wire logic [WORD_BITS-1:0] instr_word,
  input  wire logic [11:0]          host_addr,
  input  wire logic                 host_bit,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      status,
  output logic                      bit_read,
  output logic                      accumulator,
  output logic                      chain_open,
  output count_t                    executed_count,
  output count_t                    reserved_count
);

  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  // Bit memory and clearing sweep
  logic                 mem [MEM_DEPTH];
  logic                 clr_busy;
  logic [ADDR_BITS-1:0] clr_addr;

  // Execute register
  logic                 s1_v;
  logic [1:0]           s1_kind;
  logic [WORD_BITS-1:0] s1_word;
  logic [ADDR_BITS-1:0] s1_addr;
  logic                 s1_hbit;
  logic                 rd_raw;
  logic                 fwd_hit;
  logic                 fwd_bit;
  logic                 s1_mem;

  // Architectural state
  logic   acc;
  logic   chain;
  count_t exec_cnt;
  count_t rsv_cnt;

  // Execute results
  logic   acc_next;
  logic   chain_next;
  count_t exec_cnt_next;
  count_t rsv_cnt_next;
  logic   status_next;
  logic   rd_next;
  logic   s1_we;
  logic   s1_wdata;
  logic   s1_is_exec;

  logic [3:0]           s1_op;
  logic                 start_bit;
  logic                 v_eff;
  logic [ADDR_BITS-1:0] rd_addr;
  logic                 in_fire;
  logic                 s1_adv;

  // Handshake
  assign s1_adv   = s1_v && (!out_valid || out_ready);
  assign in_ready = !clr_busy && (!s1_v || s1_adv);
  assign in_fire  = in_valid && in_ready;
  assign rd_addr  = (kind == KIND_EXEC) ? instr_word[ADDR_BITS-1:0]
                                        : host_addr[ADDR_BITS-1:0];

  // Clear the memory after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Write the memory and read it on accept
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= 1'b0;
    end else if (s1_adv && s1_we) begin
      mem[s1_addr] <= s1_wdata;
    end
    if (in_fire) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // Forward a bit written by the leaving item to the entering one
  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_hit <= s1_adv && s1_we && (s1_addr == rd_addr);
      fwd_bit <= s1_wdata;
    end
  end

  assign s1_mem = fwd_hit ? fwd_bit : rd_raw;

  // Load the execute register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_fire) begin
      s1_v <= 1'b1;
    end else if (s1_adv) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind <= kind;
      s1_word <= instr_word;
      s1_addr <= rd_addr;
      s1_hbit <= host_bit;
    end
  end

  // Execute one item
  assign s1_op     = s1_word[WORD_BITS-1:OP_LSB];
  assign start_bit = chain ? acc : ((s1_op == OPC_AND) || (s1_op == OPC_ANDN));
  assign v_eff     = s1_mem ^ ((s1_op == OPC_ANDN) || (s1_op == OPC_ORN)
                               || (s1_op == OPC_XORN));

  always_comb begin
    acc_next      = acc;
    chain_next    = chain;
    exec_cnt_next = exec_cnt;
    rsv_cnt_next  = rsv_cnt;
    status_next   = 1'b0;
    rd_next       = 1'b0;
    s1_we         = 1'b0;
    s1_wdata      = acc;
    s1_is_exec    = 1'b0;
    unique case (s1_kind)
      KIND_EXEC: begin
        s1_is_exec    = 1'b1;
        exec_cnt_next = exec_cnt + 32'd1;
        unique case (s1_op) inside
          OPC_NOP, OPC_NOP_F: begin
            acc_next = acc;
          end
          OPC_AND, OPC_ANDN: begin
            acc_next   = start_bit & v_eff;
            chain_next = 1'b1;
          end
          OPC_OR, OPC_ORN: begin
            acc_next   = start_bit | v_eff;
            chain_next = 1'b1;
          end
          OPC_XOR, OPC_XORN: begin
            acc_next   = start_bit ^ v_eff;
            chain_next = 1'b1;
          end
          OPC_SET: begin
            s1_we      = acc;
            s1_wdata   = 1'b1;
            chain_next = 1'b0;
          end
          OPC_SETN: begin
            s1_we      = !acc;
            s1_wdata   = 1'b1;
            chain_next = 1'b0;
          end
          OPC_RST: begin
            s1_we      = acc;
            s1_wdata   = 1'b0;
            chain_next = 1'b0;
          end
          OPC_RSTN: begin
            s1_we      = !acc;
            s1_wdata   = 1'b0;
            chain_next = 1'b0;
          end
          OPC_ASSIGN: begin
            s1_we      = 1'b1;
            s1_wdata   = acc;
            chain_next = 1'b0;
          end
          OPC_RSV_C, OPC_RSV_D, OPC_RSV_E: begin
            status_next  = 1'b1;
            rsv_cnt_next = rsv_cnt + 32'd1;
          end
          default: begin
            acc_next = acc;
          end
        endcase
      end
      KIND_HWRITE: begin
        s1_we    = 1'b1;
        s1_wdata = s1_hbit;
      end
      KIND_HREAD: begin
        rd_next = s1_mem;
      end
      default: begin
        rd_next = 1'b0;
      end
    endcase
  end

  // Commit state when the item leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= 1'b0;
      chain    <= 1'b0;
      exec_cnt <= '0;
      rsv_cnt  <= '0;
    end else if (s1_adv) begin
      acc      <= acc_next;
      chain    <= chain_next;
      exec_cnt <= exec_cnt_next;
      rsv_cnt  <= rsv_cnt_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status   <= status_next;
      bit_read <= rd_next;
    end
  end

  assign accumulator    = acc;
  assign chain_open     = chain;
  assign executed_count = exec_cnt;
  assign reserved_count = rsv_cnt;

  // Checks
  `ASSERT_CLK(a_no_item_while_clearing, clr_busy |-> !s1_v, "item in flight during memory clear")
  `ASSERT_CLK(a_hold_on_stall, (out_valid && !out_ready) |=> $stable(executed_count) && $stable(accumulator), "state moved while result stalled")
  `ASSERT_CLK(a_exec_counts, (s1_adv && s1_is_exec) |=> executed_count == $past(executed_count) + 32'd1, "executed count did not advance")
  `ASSERT_CLK(a_forward, (in_fire && s1_adv && s1_we && (s1_addr == rd_addr)) |=> s1_mem == $past(s1_wdata), "written bit not forwarded")

endmodule

`default_nettype wire

// ===== tb/sv/tb_plc_bit_logic_executor_top.sv =====
`default_nettype none

module tb_plc_bit_logic_executor_top;
  import plcbl_pkg::*;

  localparam int          MEM_BITS       = 4096;
  localparam logic [1:0]  KIND_NONE      = 2'd3;
  localparam int          RX_HOLD_CYCLES = 300;
  localparam int          TIMEOUT_CYCLES = 1000000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] word;
    logic [11:0] haddr;
    logic        hbit;
  } beat_t;

  typedef struct packed {
    logic   status;
    logic   bit_read;
    logic   acc;
    logic   chain;
    count_t exec_cnt;
    count_t rsv_cnt;
  } result_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [1:0]  kind       = '0;
  logic [15:0] instr_word = '0;
  logic [11:0] host_addr  = '0;
  logic        host_bit   = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic        status;
  logic        bit_read;
  logic        accumulator;
  logic        chain_open;
  count_t      executed_count;
  count_t      reserved_count;

  // Predicted state of the executor
  logic [MEM_BITS-1:0] bit_image   = '0;
  logic                acc_image   = 1'b0;
  logic                chain_image = 1'b0;
  count_t              exec_total  = '0;
  count_t              rsv_total   = '0;

  result_t     pending_results[$];
  int unsigned items_sent   = 0;
  int unsigned fail_count   = 0;
  bit          src_idle_on  = 1'b0;
  bit          rx_stall_on  = 1'b0;
  int unsigned rx_hold_req  = 0;
  int unsigned rx_hold_done = 0;

  plc_bit_logic_executor_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .instr_word     (instr_word),
    .host_addr      (host_addr),
    .host_bit       (host_bit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .bit_read       (bit_read),
    .accumulator    (accumulator),
    .chain_open     (chain_open),
    .executed_count (executed_count),
    .reserved_count (reserved_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one beat to the predicted state and return the result it yields
  function automatic result_t execute_item(beat_t b);
    logic [3:0]  op;
    logic [11:0] a;
    logic        v;
    logic        start;
    result_t     r;
    r = '0;
    case (b.kind)
      KIND_EXEC: begin
        op = b.word[15:12];
        a  = b.word[11:0];
        v  = bit_image[a];
        exec_total = exec_total + 1;
        case (op)
          OPC_NOP, OPC_NOP_F: begin
          end
          OPC_AND, OPC_ANDN, OPC_OR, OPC_ORN, OPC_XOR, OPC_XORN: begin
            if (op == OPC_ANDN || op == OPC_ORN || op == OPC_XORN) v = ~v;
            // a fresh chain seeds AND forms with 1, the rest with 0
            start = (op == OPC_AND || op == OPC_ANDN);
            if (chain_image) start = acc_image;
            if (op == OPC_AND || op == OPC_ANDN) acc_image = start & v;
            else if (op == OPC_OR || op == OPC_ORN) acc_image = start | v;
            else acc_image = start ^ v;
            chain_image = 1'b1;
          end
          OPC_SET: begin
            if (acc_image) bit_image[a] = 1'b1;
            chain_image = 1'b0;
          end
          OPC_SETN: begin
            if (!acc_image) bit_image[a] = 1'b1;
            chain_image = 1'b0;
          end
          OPC_RST: begin
            if (acc_image) bit_image[a] = 1'b0;
            chain_image = 1'b0;
          end
          OPC_RSTN: begin
            if (!acc_image) bit_image[a] = 1'b0;
            chain_image = 1'b0;
          end
          OPC_ASSIGN: begin
            bit_image[a] = acc_image;
            chain_image = 1'b0;
          end
          default: begin
            // reserved: beside the executed count, only the reserved counter moves
            rsv_total = rsv_total + 1;
            r.status = 1'b1;
          end
        endcase
      end
      KIND_HWRITE: bit_image[b.haddr] = b.hbit;
      KIND_HREAD:  r.bit_read = bit_image[b.haddr];
      default: begin
      end
    endcase
    r.acc      = acc_image;
    r.chain    = chain_image;
    r.exec_cnt = exec_total;
    r.rsv_cnt  = rsv_total;
    return r;
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    else if (r < 95) return $urandom_range(1, 3);
    else return $urandom_range(12, 40);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Offer one beat, hold it until accepted, then maybe idle
  task automatic send_beat(logic [1:0] k, logic [15:0] w, logic [11:0] a, logic hb);
    beat_t       b;
    int unsigned g;
    b = {k, w, a, hb};
    in_valid   <= 1'b1;
    kind       <= k;
    instr_word <= w;
    host_addr  <= a;
    host_bit   <= hb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(execute_item(b));
    items_sent++;
    g = src_idle_on ? pick_gap() : 0;
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_random_beat();
    int unsigned r;
    logic [1:0]  k;
    r = $urandom_range(0, 99);
    if (r < 60) k = KIND_EXEC;
    else if (r < 75) k = KIND_HWRITE;
    else if (r < 92) k = KIND_HREAD;
    else k = KIND_NONE;
    send_beat(k, 16'($urandom), 12'($urandom), 1'($urandom));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    src_idle_on = 1'b0;
    rx_stall_on = 1'b0;
    send_beat(KIND_EXEC,   {OPC_NOP, 12'h000}, 12'h000, 1'b0);
    send_beat(KIND_EXEC,   {OPC_NOP_F, 12'hFFF}, 12'hFFF, 1'b1);
    send_beat(KIND_HWRITE, 16'hFFFF, 12'hFFF, 1'b1);
    send_beat(KIND_HREAD,  16'h0000, 12'hFFF, 1'b0);
    send_beat(KIND_HREAD,  16'hFFFF, 12'h000, 1'b1);
    // one chain through every logic form
    send_beat(KIND_EXEC,   {OPC_AND, 12'hFFF}, 12'h000, 1'b0);
    send_beat(KIND_EXEC,   {OPC_ANDN, 12'hFFF}, 12'h000, 1'b0);
    send_beat(KIND_EXEC,   {OPC_OR, 12'hFFF}, 12'h000, 1'b0);
    send_beat(KIND_EXEC,   {OPC_ORN, 12'h000}, 12'h000, 1'b0);
    send_beat(KIND_EXEC,   {OPC_XOR, 12'hFFF}, 12'h000, 1'b0);
    send_beat(KIND_EXEC,   {OPC_XORN, 12'h000}, 12'h000, 1'b0);
    send_beat(KIND_EXEC,   {OPC_SET, 12'h001}, 12'h000, 1'b0);
    // reserved with the chain closed, then inside an OR chain
    send_beat(KIND_EXEC,   {OPC_RSV_C, 12'h001}, 12'h000, 1'b0);
    send_beat(KIND_EXEC,   {OPC_OR, 12'h000}, 12'h000, 1'b0);
    send_beat(KIND_EXEC,   {OPC_RSV_D, 12'hFFF}, 12'h000, 1'b0);
    send_beat(KIND_EXEC,   {OPC_SETN, 12'h002}, 12'h000, 1'b0);
    send_beat(KIND_EXEC,   {OPC_XOR, 12'h001}, 12'h000, 1'b0);
    send_beat(KIND_EXEC,   {OPC_RST, 12'h001}, 12'h000, 1'b0);
    // write op that stores nothing; the chain stays closed
    send_beat(KIND_EXEC,   {OPC_RSTN, 12'h002}, 12'h000, 1'b0);
    send_beat(KIND_EXEC,   {OPC_AND, 12'h000}, 12'h000, 1'b0);
    send_beat(KIND_EXEC,   {OPC_ASSIGN, 12'hFFF}, 12'h000, 1'b0);
    send_beat(KIND_EXEC,   {OPC_RSV_E, 12'hABC}, 12'h000, 1'b0);
    send_beat(KIND_NONE,   16'hFFFF, 12'hFFF, 1'b1);
    send_beat(KIND_HREAD,  16'h0000, 12'h001, 1'b0);
    send_beat(KIND_HREAD,  16'h0000, 12'h002, 1'b0);
    send_beat(KIND_HREAD,  16'h0000, 12'hFFF, 1'b0);
    drain();
  endtask

  task automatic test_random_mix();
    src_idle_on = 1'b1;
    rx_stall_on = 1'b1;
    repeat (300) send_random_beat();
    drain();
  endtask

  // Seed two bits of a pool of four, run a logic chain over the pool, usually store, read back
  task automatic test_chains();
    logic [11:0] pool[4];
    int unsigned i;
    int unsigned n_ops;
    int unsigned n_chains;
    int unsigned r;
    logic [3:0]  op;
    logic [11:0] dst;
    src_idle_on = 1'b1;
    rx_stall_on = 1'b1;
    n_chains = 0;
    while (items_sent < 1550) begin
      for (i = 0; i < 4; i++) pool[i[1:0]] = 12'($urandom_range(0, MEM_BITS - 1));
      if ($urandom_range(0, 3) == 0) pool[3] = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
      for (i = 0; i < 2; i++) begin
        send_beat(KIND_HWRITE, 16'($urandom), pool[i[1:0]], 1'($urandom));
      end
      n_ops = $urandom_range(1, 6);
      for (i = 0; i < n_ops; i++) begin
        r = $urandom_range(0, 99);
        if (r < 88) op = 4'($urandom_range(OPC_AND, OPC_XORN));
        else if (r < 94) op = 4'($urandom_range(OPC_RSV_C, OPC_RSV_E));
        else op = $urandom_range(0, 1) ? OPC_NOP : OPC_NOP_F;
        send_beat(KIND_EXEC, {op, pool[2'($urandom_range(0, 3))]}, 12'($urandom),
                  1'($urandom));
      end
      dst = pool[2'($urandom_range(0, 3))];
      if ($urandom_range(0, 9) != 0) begin
        op = 4'($urandom_range(OPC_SET, OPC_ASSIGN));
        send_beat(KIND_EXEC, {op, dst}, 12'($urandom), 1'($urandom));
      end
      send_beat(KIND_HREAD, 16'($urandom), dst, 1'($urandom));
      if ($urandom_range(0, 4) == 0) send_random_beat();
      n_chains++;
      if (n_chains % 25 == 0) drain();
    end
    drain();
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    src_idle_on = 1'b0;
    rx_stall_on = 1'b0;
    rx_hold_req++;
    repeat (60) send_random_beat();
    drain();
  endtask

  task automatic test_full_rate();
    src_idle_on = 1'b0;
    rx_stall_on = 1'b0;
    repeat (300) send_random_beat();
    drain();
  endtask

  // Drive result-side ready: long hold on request, else random stalls
  always begin : rx_side
    int unsigned g;
    @(posedge clk);
    if (rx_hold_req != rx_hold_done) begin
      out_ready <= 1'b0;
      repeat (RX_HOLD_CYCLES) @(posedge clk);
      rx_hold_done = rx_hold_req;
      out_ready <= 1'b1;
    end else begin
      g = rx_stall_on ? pick_gap() : 0;
      if (g != 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("bit_read", 32'(want.bit_read), 32'(bit_read));
        check_field("accumulator", 32'(want.acc), 32'(accumulator));
        check_field("chain_open", 32'(want.chain), 32'(chain_open));
        check_field("executed_count", want.exec_cnt, executed_count);
        check_field("reserved_count", want.rsv_cnt, reserved_count);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix();
    test_chains();
    test_backpressure();
    test_full_rate();
    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 8);
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/plcbl_pkg.sv
design/plc_bit_logic_executor_top.sv
tb/sv/tb_plc_bit_logic_executor_top.sv
